// ===== hdl/assert_macros.svh =====
// assertion macros used by the converter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// check a property on every clock edge outside reset
`define RDC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check a property on every clock edge, reset included
`define RDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RDC_ASSERT(lbl, clk, rst, prop, msg)
`define RDC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/rdc_pkg.sv =====
// shared types and constants of the radix digit converter
`default_nettype none
package rdc_pkg;

  localparam int RADIX_W  = 16;
  localparam int DIGIT_W  = 17;
  localparam int STATUS_W = 2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_RADIX = 2'd2;

  // smallest radix that is accepted
  localparam logic [RADIX_W-1:0] RADIX_MIN = 16'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_POP,
    ST_LOAD,
    ST_OUT
  } rdc_state_t;

  // digit stack commands
  typedef struct packed {
    logic push;
    logic pop;
  } rdc_stk_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/rdc_divider.sv =====
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module rdc_divider #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [VALUE_WIDTH-1:0]      dividend,
  input  wire logic [rdc_pkg::RADIX_W-1:0] divisor,
  output logic                             done,
  output logic [VALUE_WIDTH-1:0]           quotient,
  output logic [rdc_pkg::RADIX_W-1:0]      remainder
);

  localparam int CNT_W = $clog2(VALUE_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

  logic                        busy;
  logic [CNT_W-1:0]            cnt;
  logic [VALUE_WIDTH-1:0]      quo;
  logic [rdc_pkg::RADIX_W-1:0] rem;

  logic [rdc_pkg::RADIX_W:0]   shifted;
  logic [rdc_pkg::RADIX_W+1:0] diff;
  logic                        fits;

  // trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    shifted = {rem, quo[VALUE_WIDTH-1]};
    diff    = {1'b0, shifted} - {2'b00, divisor};
    fits    = !diff[rdc_pkg::RADIX_W+1];
  end

  // control: busy flag, bit counter, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_LAST;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient shifts in from the right, remainder restores
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[VALUE_WIDTH-2:0], fits};
      rem <= fits ? diff[rdc_pkg::RADIX_W-1:0] : shifted[rdc_pkg::RADIX_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule
`default_nettype wire

// ===== hdl/rdc_stack.sv =====
// digit stack: memory with push at the count and registered pop read
`default_nettype none
module rdc_stack #(
  parameter int DEPTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire rdc_pkg::rdc_stk_ctrl_t      ctrl,
  input  wire logic [rdc_pkg::DIGIT_W-1:0] push_data,
  output logic [rdc_pkg::DIGIT_W-1:0]      rd_data,
  output logic [$clog2(DEPTH+1)-1:0]       count
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  logic [rdc_pkg::DIGIT_W-1:0] mem [DEPTH];
  logic [CNT_W-1:0]            top_idx;
  logic                        full;

  always_comb begin
    top_idx = count - 1'b1;
    full    = (count == FULL);
  end

  // fill count; pushes onto a full stack are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.push && !full) begin
      count <= count + 1'b1;
    end else if (ctrl.pop) begin
      count <= top_idx;
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (ctrl.push && !full) begin
      mem[count[AW-1:0]] <= push_data;
    end
    if (ctrl.pop) begin
      rd_data <= mem[top_idx[AW-1:0]];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/radix_digit_converter.sv =====
// top level of the radix digit converter: sequencer, divider and digit stack
//
//   channel  direction  fields                handshake
//   input    in         value, radix          in_valid / in_ready
//   output   out        digit, last, status   out_valid / out_ready
//
// one item at a time; in_ready is high only while idle
// each digit takes one pass through the shared bit-serial divider
// each result then goes through stack read, load and show, plus output stall
// bad radix and zero value give their single result in the cycle after they are taken
// reset clears the sequencer and the stack count; stack contents need none
`default_nettype none
`include "assert_macros.svh"
module radix_digit_converter #(
  parameter int DIGIT_DEPTH = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [VALUE_WIDTH-1:0]       value,
  input  wire logic [rdc_pkg::RADIX_W-1:0]  radix,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [rdc_pkg::DIGIT_W-1:0]       digit,
  output logic                              last,
  output logic [rdc_pkg::STATUS_W-1:0]      status
);

  localparam int CNT_W = $clog2(DIGIT_DEPTH + 1);

  rdc_pkg::rdc_state_t         state, state_next;
  logic                        neg;
  logic [rdc_pkg::RADIX_W-1:0] radix_r;

  logic                        div_start;
  logic [VALUE_WIDTH-1:0]      div_dividend;
  logic                        div_done;
  logic [VALUE_WIDTH-1:0]      div_quotient;
  logic [rdc_pkg::RADIX_W-1:0] div_remainder;

  rdc_pkg::rdc_stk_ctrl_t      stk_ctrl;
  logic [rdc_pkg::DIGIT_W-1:0] push_digit;
  logic [rdc_pkg::DIGIT_W-1:0] stk_rd_data;
  logic [CNT_W-1:0]            stk_count;

  logic                        accept;
  logic                        bad_radix;
  logic                        zero_value;
  logic [VALUE_WIDTH-1:0]      magnitude;

  // input decode and magnitude of the value
  always_comb begin
    accept     = in_valid && in_ready;
    bad_radix  = (radix < rdc_pkg::RADIX_MIN);
    zero_value = (value == '0);
    magnitude  = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
  end

  // remainder carries the sign of the dividend
  always_comb begin
    push_digit = neg ? (rdc_pkg::DIGIT_W'(0) - {1'b0, div_remainder})
                     : {1'b0, div_remainder};
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and unit commands
  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = div_quotient;
    stk_ctrl     = '0;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    unique case (state)
      rdc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (bad_radix || zero_value) begin
            state_next = rdc_pkg::ST_OUT;
          end else begin
            div_start    = 1'b1;
            div_dividend = magnitude;
            state_next   = rdc_pkg::ST_DIVIDE;
          end
        end
      end
      rdc_pkg::ST_DIVIDE: begin
        if (div_done) begin
          stk_ctrl.push = 1'b1;
          if (div_quotient != '0) begin
            div_start = 1'b1;
          end else begin
            state_next = rdc_pkg::ST_POP;
          end
        end
      end
      rdc_pkg::ST_POP: begin
        stk_ctrl.pop = 1'b1;
        state_next   = rdc_pkg::ST_LOAD;
      end
      rdc_pkg::ST_LOAD: begin
        state_next = rdc_pkg::ST_OUT;
      end
      rdc_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = last ? rdc_pkg::ST_IDLE : rdc_pkg::ST_POP;
        end
      end
      default: begin
        state_next = rdc_pkg::ST_IDLE;
      end
    endcase
  end

  // item context and output register
  always_ff @(posedge clk) begin
    if (accept) begin
      neg     <= value[VALUE_WIDTH-1];
      radix_r <= radix;
      digit   <= '0;
      last    <= 1'b1;
      status  <= bad_radix ? rdc_pkg::STATUS_BAD_RADIX : rdc_pkg::STATUS_ZERO;
    end else if (state == rdc_pkg::ST_LOAD) begin
      digit  <= stk_rd_data;
      last   <= (stk_count == '0);
      status <= rdc_pkg::STATUS_OK;
    end
  end

  rdc_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_start && accept ? radix : radix_r),
    .done     (div_done),
    .quotient (div_quotient),
    .remainder(div_remainder)
  );

  rdc_stack #(
    .DEPTH(DIGIT_DEPTH)
  ) u_stack (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (stk_ctrl),
    .push_data(push_digit),
    .rd_data  (stk_rd_data),
    .count    (stk_count)
  );

  // checks
  `RDC_ASSERT_ALWAYS(a_in_out_excl, clk, !(in_ready && out_valid), "ready while result shown")
  `RDC_ASSERT(a_last_to_idle, clk, rst, (out_valid && out_ready && last) |=> in_ready, "no idle after last")
  `RDC_ASSERT(a_status_last, clk, rst, (out_valid && status != rdc_pkg::STATUS_OK) |-> last, "status item not last")
  `RDC_ASSERT(a_pop_nonempty, clk, rst, stk_ctrl.pop |-> (stk_count != '0), "pop from empty stack")

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// self-checking bench for the radix digit converter: directed table, then random items
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rdc_pkg::*;

  localparam int VALUE_W     = 32;
  localparam int DIGIT_DEPTH = 32;
  localparam int PHASE_ITEMS = 80;

  // one expected result item
  typedef struct {
    logic [DIGIT_W-1:0]  digit;
    logic                last;
    logic [STATUS_W-1:0] status;
  } digit_rec_t;

  // one row of the directed table; typed rows carry their single result
  typedef struct {
    logic [VALUE_W-1:0]  value;
    logic [RADIX_W-1:0]  radix;
    bit                  typed;
    logic [DIGIT_W-1:0]  digit;
    logic [STATUS_W-1:0] status;
  } conv_row_t;

  localparam int N_ROWS = 24;

  conv_row_t conv_rows [N_ROWS] = '{
    // bad radix and zero value, bad radix checked first
    '{32'sd0,           16'd10,    1'b1, 17'sd0,      STATUS_ZERO},
    '{32'sd5,           16'd0,     1'b1, 17'sd0,      STATUS_BAD_RADIX},
    '{32'sd5,           16'd1,     1'b1, 17'sd0,      STATUS_BAD_RADIX},
    '{32'sd0,           16'd0,     1'b1, 17'sd0,      STATUS_BAD_RADIX},
    '{32'sd0,           16'd1,     1'b1, 17'sd0,      STATUS_BAD_RADIX},
    '{32'h8000_0000,    16'd0,     1'b1, 17'sd0,      STATUS_BAD_RADIX},
    '{32'sd0,           16'd65535, 1'b1, 17'sd0,      STATUS_ZERO},
    // single digits, including the digit extremes
    '{32'sd1,           16'd2,     1'b1, 17'sd1,      STATUS_OK},
    '{-32'sd1,          16'd2,     1'b1, -17'sd1,     STATUS_OK},
    '{32'sd65534,       16'd65535, 1'b1, 17'sd65534,  STATUS_OK},
    '{-32'sd65534,      16'd65535, 1'b1, -17'sd65534, STATUS_OK},
    // value extremes and longest digit strings
    '{32'h7FFF_FFFF,    16'd2,     1'b0, '0, STATUS_OK},
    '{32'h8000_0000,    16'd2,     1'b0, '0, STATUS_OK},
    '{32'h8000_0000,    16'd65535, 1'b0, '0, STATUS_OK},
    '{32'h7FFF_FFFF,    16'd65535, 1'b0, '0, STATUS_OK},
    '{32'h8000_0000,    16'd3,     1'b0, '0, STATUS_OK},
    '{32'h8000_0000,    16'h8000,  1'b0, '0, STATUS_OK},
    '{32'sd65535,       16'd65535, 1'b0, '0, STATUS_OK},
    // everyday values of either sign
    '{32'sd255,         16'd16,    1'b0, '0, STATUS_OK},
    '{-32'sd255,        16'd16,    1'b0, '0, STATUS_OK},
    '{32'sd12345,       16'd10,    1'b0, '0, STATUS_OK},
    '{-32'sd12345,      16'd10,    1'b0, '0, STATUS_OK},
    // alternating bit patterns on both fields
    '{32'hAAAA_AAAA,    16'hAAAA,  1'b0, '0, STATUS_OK},
    '{32'h5555_5555,    16'h5555,  1'b0, '0, STATUS_OK}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [VALUE_W-1:0]  value = '0;
  logic [RADIX_W-1:0]  radix = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [DIGIT_W-1:0]  digit;
  logic                last;
  logic [STATUS_W-1:0] status;

  // typed expectation travelling with the item on the input side
  logic                row_typed = 1'b0;
  logic [DIGIT_W-1:0]  row_digit = '0;
  logic [STATUS_W-1:0] row_status = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  digit_rec_t digits_due [$];
  int n_items, n_digits, n_bad_radix, n_zero_value, n_errors;

  radix_digit_converter u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .radix     (radix),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .digit     (digit),
    .last      (last),
    .status    (status)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected results of a value in a radix onto the queue: digits most significant first, or one status item
  function automatic void radix_digits(input logic [VALUE_W-1:0] v_raw,
                                       input logic [RADIX_W-1:0] r_raw);
    longint             v;
    longint             r;
    longint             rem;
    logic [DIGIT_W-1:0] stk [DIGIT_DEPTH];
    int                 depth;
    int                 i;
    v = longint'(signed'(v_raw));
    r = longint'(r_raw);
    depth = 0;
    if (r_raw < RADIX_MIN) begin
      digits_due.push_back('{'0, 1'b1, STATUS_BAD_RADIX});
      return;
    end
    if (v == 0) begin
      digits_due.push_back('{'0, 1'b1, STATUS_ZERO});
      return;
    end
    // truncating division; remainders keep the sign of the value
    while (v != 0) begin
      rem = v % r;
      if (depth < DIGIT_DEPTH) begin
        stk[depth] = DIGIT_W'(rem);
        depth++;
      end
      v = v / r;
    end
    for (i = depth - 1; i >= 0; i--)
      digits_due.push_back('{stk[i], (i == 0), STATUS_OK});
  endfunction

  // random value: full range, small magnitudes, zero and extremes
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return VALUE_W'($urandom);
      4, 5:       return VALUE_W'(int'($urandom_range(600)) - 300);
      6:          return '0;
      7: begin
        case ($urandom_range(3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      8:          return VALUE_W'($urandom) & ((32'd1 << $urandom_range(31)) - 32'd1);
      default:    return VALUE_W'($urandom) | 32'h8000_0000;
    endcase
  endfunction

  // random radix: small bases most often, some wide ones, a few bad ones
  function automatic logic [RADIX_W-1:0] pick_radix();
    case ($urandom_range(19))
      0:                      return RADIX_W'($urandom_range(1));
      1, 2, 3, 4, 5, 6, 7, 8: return RADIX_W'($urandom_range(16, 2));
      9, 10, 11, 12:          return RADIX_W'($urandom_range(300, 17));
      13, 14, 15, 16:         return RADIX_W'($urandom_range(65535));
      17:                     return $urandom_range(1) ? 16'hFFFF : 16'h8000;
      default:                return RADIX_W'(32'd1 << $urandom_range(15, 1));
    endcase
  endfunction

  // offer one item, with a random gap first, and hold it until taken
  task automatic send_item(input logic [VALUE_W-1:0] v, input logic [RADIX_W-1:0] r,
                           input bit typed, input logic [DIGIT_W-1:0] d,
                           input logic [STATUS_W-1:0] s);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    value      <= v;
    radix      <= r;
    row_typed  <= typed;
    row_digit  <= d;
    row_status <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  // result side back-pressure
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // expectations on each accepted item, checks on each accepted result
  always @(posedge clk) begin
    digit_rec_t due;
    if (!rst) begin
      if (in_valid && in_ready) begin
        n_items++;
        if (radix < RADIX_MIN) n_bad_radix++;
        else if (value == '0) n_zero_value++;
        if (row_typed) digits_due.push_back('{row_digit, 1'b1, row_status});
        else radix_digits(value, radix);
      end
      if (out_valid && out_ready) begin
        if (digits_due.size() == 0) begin
          $error("result with nothing pending: digit %0d last %0b status %0d",
                 $signed(digit), last, status);
          n_errors++;
        end else begin
          due = digits_due.pop_front();
          if (status == STATUS_OK) n_digits++;
          if (digit !== due.digit) begin
            $error("digit: expected %0d, got %0d", $signed(due.digit), $signed(digit));
            n_errors++;
          end
          if (last !== due.last) begin
            $error("last: expected %0b, got %0b", due.last, last);
            n_errors++;
          end
          if (status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, status);
            n_errors++;
          end
        end
      end
    end
  end

  // stimulus: reset, directed table, four phases of random items, drain
  initial begin
    int phase;
    int i;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (conv_rows[k])
      send_item(conv_rows[k].value, conv_rows[k].radix, conv_rows[k].typed,
                conv_rows[k].digit, conv_rows[k].status);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      for (i = 0; i < PHASE_ITEMS; i++)
        send_item(pick_value(), pick_radix(), 1'b0, '0, STATUS_OK);
    end
    in_valid <= 1'b0;

    // the last item's expectations are queued by the end of this cycle
    @(posedge clk);

    // let the last results arrive, then watch for strays
    while (digits_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("converted %0d items into %0d digits; %0d bad radix, %0d zero value",
             n_items, n_digits, n_bad_radix, n_zero_value);
    $display("idling phases: none, sender gaps, receiver stalls, both; %0d mismatches",
             n_errors);
    if (n_errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #30_000_000;
    $display("timeout with %0d results still pending", digits_due.size());
    $display("FAIL");
    $finish;
  end

endmodule
